/* design/nat_session_translation_top_macros.svh */
// Assertion macros shared by the NAT session translation design.
`ifndef NAT_SESSION_TRANSLATION_TOP_MACROS_SVH
`define NAT_SESSION_TRANSLATION_TOP_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define NST_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Property whose consequence must hold in the cycle after its trigger.
`define NST_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

/* design/nst_pkg.sv */
// Shared constants, codes and types of the NAT session translation block.
`default_nettype none
package nst_pkg;

  // Session table size and derived widths.
  localparam int SESSIONS = 1024;
  localparam int SESS_AW  = $clog2(SESSIONS);
  localparam int FILL_W   = SESS_AW + 1;

  // Reverse map: one row per protocol slot and outside port.
  localparam int PORT_SPACE = 65536;
  localparam int REV_DEPTH  = 3 * PORT_SPACE;
  localparam int REV_AW     = $clog2(REV_DEPTH);

  // Dynamic port range for TCP and UDP.
  localparam logic [15:0] DYN_LOW      = 16'd1024;
  localparam logic [15:0] DYN_LAST_RES = 16'd64511;

  // Protocol numbers and ICMP types.
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] ICMP_REQ   = 8'd8;
  localparam logic [7:0] ICMP_REPLY = 8'd0;

  // Protocol slots of the counters and the reverse map.
  localparam logic [1:0] SLOT_TCP  = 2'd0;
  localparam logic [1:0] SLOT_UDP  = 2'd1;
  localparam logic [1:0] SLOT_ICMP = 2'd2;

  // Result actions.
  localparam logic [1:0] ACT_PASS = 2'd0;
  localparam logic [1:0] ACT_OUT  = 2'd1;
  localparam logic [1:0] ACT_IN   = 2'd2;

  // Register indexes.
  localparam logic [1:0] REG_SUBNET = 2'd0;
  localparam logic [1:0] REG_MASK   = 2'd1;
  localparam logic [1:0] REG_PUBLIC = 2'd2;

  typedef struct packed {
    logic [31:0] subnet;
    logic [31:0] mask;
    logic [31:0] pub_addr;
  } cfg_t;

  typedef struct packed {
    logic [63:0]        hosts;
    logic [1:0]         proto;
    logic [15:0]        sport;
    logic [15:0]        dport;
    logic [15:0]        nat;
    logic [SESS_AW-1:0] age;
  } sess_entry_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [15:0] port;
  } rev_entry_t;

endpackage
`default_nettype wire

/* design/nst_ram.sv */
// Generic memory with one write port and one registered read port.
`default_nettype none
module nst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/nst_cfg_regs.sv */
// Configuration registers behind the APB-style port.
`default_nettype none
module nst_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output nst_pkg::cfg_t    cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        nst_pkg::REG_SUBNET: cfg.subnet   <= pwdata;
        nst_pkg::REG_MASK:   cfg.mask     <= pwdata;
        nst_pkg::REG_PUBLIC: cfg.pub_addr <= pwdata;
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    case (paddr[3:2])
      nst_pkg::REG_SUBNET: prdata = cfg.subnet;
      nst_pkg::REG_MASK:   prdata = cfg.mask;
      nst_pkg::REG_PUBLIC: prdata = cfg.pub_addr;
      default:             prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

/* design/nat_session_translation_top.sv */
// Top level of the NAT session translation block: sequencer, session table and reverse map.
`default_nettype none
// Source NAT decision for one parsed IPv4 header per transaction. After reset the
// reverse map is cleared one row a cycle, all 196608 rows, with in_stall high. A
// header that passes goes from dispatch straight to the finish state, an inbound
// one reads the reverse map on the way. An outbound header sweeps the session
// table through its single memory read port: one pass over the fill stored
// sessions (at most 1024) to search and find the least recently used entry,
// then, on a hit or a new session, a second pass that rewrites the LRU ranks.
// One header is in work at a time; the result sits in an output register while
// the next header is taken.
module nat_session_translation_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        is_ipv4,
  input  wire logic        fragmented,
  input  wire logic [7:0]  protocol,
  input  wire logic [31:0] src_ip,
  input  wire logic [31:0] dst_ip,
  input  wire logic [15:0] src_port,
  input  wire logic [15:0] dst_port,
  input  wire logic [7:0]  icmp_type,
  input  wire logic        l4_header_ok,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [1:0]  action,
  output logic      [31:0] new_src_ip,
  output logic      [31:0] new_dst_ip,
  output logic      [15:0] new_src_port,
  output logic      [15:0] new_dst_port
);

  `include "nat_session_translation_top_macros.svh"

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_DISPATCH = 8'b0000_0100,
    ST_SCAN     = 8'b0000_1000,
    ST_DECIDE   = 8'b0001_0000,
    ST_UPDATE   = 8'b0010_0000,
    ST_REVRD    = 8'b0100_0000,
    ST_FIN      = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  nst_pkg::cfg_t cfg;

  // Captured header.
  logic        r_is_ipv4, r_fragmented, r_l4_ok;
  logic [7:0]  r_protocol, r_icmp_type;
  logic [31:0] r_src_ip, r_dst_ip;
  logic [15:0] r_src_port, r_dst_port;

  // Pending result.
  logic [1:0]  res_action;
  logic [31:0] res_sip, res_dip;
  logic [15:0] res_sp, res_dp;

  // Session sweep control.
  logic [nst_pkg::FILL_W-1:0]  fill, scan_cnt;
  logic                        pend;
  logic [nst_pkg::SESS_AW-1:0] pend_idx, hit_idx, lru_idx, slot_idx, limit, hit_age;
  logic                        found, limited, write_new;
  logic [15:0]                 hit_nat;

  // Port allocation counters.
  logic [31:0] cnt [0:2];
  logic [15:0] res_mod [0:1];

  logic [nst_pkg::REV_AW-1:0] clr_cnt;

  // Memory ports.
  logic                        sess_we, sess_re;
  logic [nst_pkg::SESS_AW-1:0] sess_waddr, sess_raddr;
  nst_pkg::sess_entry_t        sess_wdata, sess_rd;
  logic                        rev_we, rev_re;
  logic [nst_pkg::REV_AW-1:0]  rev_waddr, rev_raddr;
  nst_pkg::rev_entry_t         rev_wdata, rev_rd;

  // Decoding.
  logic        inside_src, inside_dst, usable, parsed, is_icmp, outbound, inbound;
  logic [1:0]  slot_proto;
  logic [15:0] key_dport, alloc_nat;
  logic [31:0] raw;
  logic        issue, match, full, in_acc, out_free;

  nst_cfg_regs u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  nst_ram #(
    .WIDTH($bits(nst_pkg::sess_entry_t)), .DEPTH(nst_pkg::SESSIONS), .AW(nst_pkg::SESS_AW)
  ) u_sess_ram (
    .clk, .we(sess_we), .waddr(sess_waddr), .wdata(sess_wdata),
    .re(sess_re), .raddr(sess_raddr), .rdata(sess_rd)
  );

  nst_ram #(
    .WIDTH($bits(nst_pkg::rev_entry_t)), .DEPTH(nst_pkg::REV_DEPTH), .AW(nst_pkg::REV_AW)
  ) u_rev_ram (
    .clk, .we(rev_we), .waddr(rev_waddr), .wdata(rev_wdata),
    .re(rev_re), .raddr(rev_raddr), .rdata(rev_rd)
  );

  // Header classification.
  always_comb begin
    inside_src = (r_src_ip & cfg.mask) == cfg.subnet;
    inside_dst = (r_dst_ip & cfg.mask) == cfg.subnet;
    usable     = r_is_ipv4 && !r_fragmented;
    parsed     = 1'b0;
    is_icmp    = 1'b0;
    slot_proto = nst_pkg::SLOT_TCP;
    key_dport  = r_dst_port;
    if (usable && r_l4_ok) begin
      if (r_protocol == nst_pkg::PROTO_TCP) begin
        parsed = 1'b1;
      end else if (r_protocol == nst_pkg::PROTO_UDP) begin
        parsed     = 1'b1;
        slot_proto = nst_pkg::SLOT_UDP;
      end else if (r_protocol == nst_pkg::PROTO_ICMP &&
                   (r_icmp_type == nst_pkg::ICMP_REQ ||
                    r_icmp_type == nst_pkg::ICMP_REPLY)) begin
        parsed     = 1'b1;
        is_icmp    = 1'b1;
        slot_proto = nst_pkg::SLOT_ICMP;
        key_dport  = 16'd0;
      end
    end
    outbound = usable && inside_src && !inside_dst;
    inbound  = usable && !outbound && parsed && (r_dst_ip == cfg.pub_addr);
  end

  // Sweep and allocation helpers.
  assign issue     = scan_cnt < fill;
  assign full      = fill == nst_pkg::FILL_W'(nst_pkg::SESSIONS);
  assign match     = sess_rd.hosts == {r_src_ip, r_dst_ip} && sess_rd.proto == slot_proto &&
                     sess_rd.sport == r_src_port && sess_rd.dport == key_dport;
  assign raw       = cnt[slot_proto];
  assign alloc_nat = is_icmp ? raw[15:0] : nst_pkg::DYN_LOW + res_mod[slot_proto[0]];
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = state != ST_IDLE;

  // Session memory port control.
  always_comb begin
    sess_re    = (state == ST_SCAN || state == ST_UPDATE) && issue;
    sess_raddr = scan_cnt[nst_pkg::SESS_AW-1:0];
    sess_we    = (state == ST_UPDATE) && pend;
    sess_waddr = pend_idx;
    sess_wdata = sess_rd;
    if (pend_idx == slot_idx) begin
      if (write_new) begin
        sess_wdata.hosts = {r_src_ip, r_dst_ip};
        sess_wdata.proto = slot_proto;
        sess_wdata.sport = r_src_port;
        sess_wdata.dport = key_dport;
        sess_wdata.nat   = res_sp;
      end
      sess_wdata.age = '0;
    end else if (!limited || sess_rd.age < limit) begin
      sess_wdata.age = sess_rd.age + 1'b1;
    end
  end

  // Reverse map port control.
  always_comb begin
    rev_re    = state == ST_DISPATCH;
    rev_raddr = {slot_proto, is_icmp ? r_src_port : r_dst_port};
    rev_we    = 1'b0;
    rev_waddr = {slot_proto, alloc_nat};
    rev_wdata = {1'b1, r_src_ip, r_src_port};
    if (state == ST_CLEAR) begin
      rev_we    = 1'b1;
      rev_waddr = clr_cnt;
      rev_wdata = '0;
    end else if (state == ST_DECIDE && !found && alloc_nat != 16'd0) begin
      rev_we = 1'b1;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == nst_pkg::REV_AW'(nst_pkg::REV_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (outbound && parsed) state_next = ST_SCAN;
        else if (inbound) state_next = ST_REVRD;
        else state_next = ST_FIN;
      end
      ST_SCAN: begin
        if (!issue && !pend) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (found || alloc_nat != 16'd0) state_next = ST_UPDATE;
        else state_next = ST_FIN;
      end
      ST_UPDATE: begin
        if (!issue && !pend) state_next = ST_FIN;
      end
      ST_REVRD: state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      cnt[0]    <= '0;
      cnt[1]    <= '0;
      cnt[2]    <= '0;
      res_mod[0] <= '0;
      res_mod[1] <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      // Output register handshake.
      if (state == ST_FIN && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      // Sweep read pipeline.
      pend <= (state == ST_SCAN || state == ST_UPDATE) && issue;
      // New session: advance the counter and grow the table while it is not full.
      if (state == ST_DECIDE && !found) begin
        cnt[slot_proto] <= raw + 1'b1;
        if (!is_icmp) begin
          if (raw == 32'hFFFF_FFFF || res_mod[slot_proto[0]] == nst_pkg::DYN_LAST_RES)
            res_mod[slot_proto[0]] <= '0;
          else
            res_mod[slot_proto[0]] <= res_mod[slot_proto[0]] + 1'b1;
        end
        if (alloc_nat != 16'd0 && !full) fill <= fill + 1'b1;
      end
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      r_is_ipv4    <= is_ipv4;
      r_fragmented <= fragmented;
      r_protocol   <= protocol;
      r_src_ip     <= src_ip;
      r_dst_ip     <= dst_ip;
      r_src_port   <= src_port;
      r_dst_port   <= dst_port;
      r_icmp_type  <= icmp_type;
      r_l4_ok      <= l4_header_ok;
    end
    pend_idx <= scan_cnt[nst_pkg::SESS_AW-1:0];
    if ((state == ST_SCAN || state == ST_UPDATE) && issue) scan_cnt <= scan_cnt + 1'b1;
    case (state)
      ST_DISPATCH: begin
        res_action <= nst_pkg::ACT_PASS;
        res_sip    <= r_src_ip;
        res_dip    <= r_dst_ip;
        res_sp     <= r_src_port;
        res_dp     <= r_dst_port;
        scan_cnt   <= '0;
        found      <= 1'b0;
      end
      ST_SCAN: begin
        // First matching session and the oldest entry.
        if (pend) begin
          if (!found && match) begin
            found   <= 1'b1;
            hit_idx <= pend_idx;
            hit_age <= sess_rd.age;
            hit_nat <= sess_rd.nat;
          end
          if (sess_rd.age == nst_pkg::SESS_AW'(nst_pkg::SESSIONS - 1)) lru_idx <= pend_idx;
        end
      end
      ST_DECIDE: begin
        scan_cnt <= '0;
        if (found) begin
          slot_idx   <= hit_idx;
          limit      <= hit_age;
          limited    <= 1'b1;
          write_new  <= 1'b0;
          res_action <= nst_pkg::ACT_OUT;
          res_sip    <= cfg.pub_addr;
          res_sp     <= hit_nat;
          if (is_icmp) res_dp <= hit_nat;
        end else if (alloc_nat != 16'd0) begin
          slot_idx   <= full ? lru_idx : fill[nst_pkg::SESS_AW-1:0];
          limit      <= nst_pkg::SESS_AW'(nst_pkg::SESSIONS - 1);
          limited    <= full;
          write_new  <= 1'b1;
          res_action <= nst_pkg::ACT_OUT;
          res_sip    <= cfg.pub_addr;
          res_sp     <= alloc_nat;
          if (is_icmp) res_dp <= alloc_nat;
        end
      end
      ST_REVRD: begin
        if (rev_rd.valid) begin
          res_action <= nst_pkg::ACT_IN;
          res_dip    <= rev_rd.ip;
          res_dp     <= rev_rd.port;
          if (is_icmp) res_sp <= rev_rd.port;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          action       <= res_action;
          new_src_ip   <= res_sip;
          new_dst_ip   <= res_dip;
          new_src_port <= res_sp;
          new_dst_port <= res_dp;
        end
      end
      default: ;
    endcase
  end

  // Checks on the sequencer and the session table.
  `NST_ASSERT_NOW(a_fill_bound, fill <= nst_pkg::FILL_W'(nst_pkg::SESSIONS), "fill overflow")
  `NST_ASSERT_NOW(a_slot_in_table, state != ST_UPDATE || {1'b0, slot_idx} < fill, "bad slot")
  `NST_ASSERT_NEXT(a_accept_dispatch, in_acc, state == ST_DISPATCH, "accept lost")

endmodule
`default_nettype wire

/* tb/sv/nat_session_translation_checker.sv */
// Checker of the NAT session translation block: watches both channels, predicts and compares.
module nat_session_translation_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        is_ipv4,
  input  wire logic        fragmented,
  input  wire logic [7:0]  protocol,
  input  wire logic [31:0] src_ip,
  input  wire logic [31:0] dst_ip,
  input  wire logic [15:0] src_port,
  input  wire logic [15:0] dst_port,
  input  wire logic [7:0]  icmp_type,
  input  wire logic        l4_header_ok,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  action,
  input  wire logic [31:0] new_src_ip,
  input  wire logic [31:0] new_dst_ip,
  input  wire logic [15:0] new_src_port,
  input  wire logic [15:0] new_dst_port,
  output int               fails,
  output int               pending
);

  typedef struct packed {
    logic [1:0]  act;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sp;
    logic [15:0] dp;
  } xlat_t;

  // Shadow copy of the registers.
  logic [31:0] cfg_subnet = '0;
  logic [31:0] cfg_mask   = '0;
  logic [31:0] cfg_public = '0;

  // Shadow session table, reverse map and port counters.
  logic [63:0] sess_hosts [nst_pkg::SESSIONS];
  logic [33:0] sess_ports [nst_pkg::SESSIONS];
  logic [15:0] sess_nat   [nst_pkg::SESSIONS];
  bit          sess_valid [nst_pkg::SESSIONS];
  int unsigned sess_age   [nst_pkg::SESSIONS];
  logic [31:0] rmap_ip    [int];
  logic [15:0] rmap_port  [int];
  logic [31:0] port_count [3];

  xlat_t expected_xlat [$];

  assign pending = expected_xlat.size();

  initial begin
    fails = 0;
    for (int i = 0; i < nst_pkg::SESSIONS; i++) begin
      sess_valid[i] = 0;
      sess_age[i]   = 0;
    end
    for (int i = 0; i < 3; i++) port_count[i] = '0;
  end

  function automatic bit is_inside(logic [31:0] a);
    return (a & cfg_mask) == cfg_subnet;
  endfunction

  // Make one entry the most recent and push younger entries back by one.
  function automatic void make_recent(int slot, bit was_valid);
    int unsigned lim;
    lim = was_valid ? sess_age[slot] : 32'hFFFF_FFFF;
    for (int i = 0; i < nst_pkg::SESSIONS; i++)
      if (i != slot && sess_valid[i] && sess_age[i] < lim) sess_age[i]++;
    sess_age[slot] = 0;
  endfunction

  // Lowest free slot, else the least recently used one.
  function automatic int victim_slot();
    int best;
    int unsigned best_age;
    best = 0;
    best_age = 0;
    for (int i = 0; i < nst_pkg::SESSIONS; i++)
      if (!sess_valid[i]) return i;
    for (int i = 0; i < nst_pkg::SESSIONS; i++)
      if (sess_age[i] >= best_age) begin
        best_age = sess_age[i];
        best = i;
      end
    return best;
  endfunction

  // Work out the translation of one header and update the shadow state.
  function automatic xlat_t translate(logic v4, logic frag, logic [7:0] pr, logic [31:0] sip,
                                      logic [31:0] dip, logic [15:0] sp, logic [15:0] dp,
                                      logic [7:0] ty, logic ok);
    xlat_t r;
    bit parsed, icmp, found;
    logic [1:0] slot_proto;
    logic [15:0] key_dp, nat, key;
    logic [63:0] hosts;
    logic [33:0] ports;
    logic [31:0] raw;
    int hit, s, ridx;
    bit was_v;
    r = '{nst_pkg::ACT_PASS, sip, dip, sp, dp};
    parsed = 0;
    icmp = 0;
    slot_proto = nst_pkg::SLOT_TCP;
    key_dp = dp;
    if (v4 && !frag && ok) begin
      if (pr == nst_pkg::PROTO_TCP) begin
        parsed = 1;
        slot_proto = nst_pkg::SLOT_TCP;
      end else if (pr == nst_pkg::PROTO_UDP) begin
        parsed = 1;
        slot_proto = nst_pkg::SLOT_UDP;
      end else if (pr == nst_pkg::PROTO_ICMP &&
                   (ty == nst_pkg::ICMP_REQ || ty == nst_pkg::ICMP_REPLY)) begin
        parsed = 1;
        icmp = 1;
        slot_proto = nst_pkg::SLOT_ICMP;
        key_dp = '0;
      end
    end
    if (!(v4 && !frag)) return r;
    if (is_inside(sip) && !is_inside(dip)) begin
      if (!parsed) return r;
      hosts = {sip, dip};
      ports = {slot_proto, sp, key_dp};
      found = 0;
      hit = 0;
      for (int i = 0; i < nst_pkg::SESSIONS; i++)
        if (sess_valid[i] && sess_hosts[i] == hosts && sess_ports[i] == ports) begin
          hit = i;
          found = 1;
          break;
        end
      if (found) begin
        make_recent(hit, 1);
        nat = sess_nat[hit];
      end else begin
        raw = port_count[slot_proto];
        port_count[slot_proto] = raw + 1;
        nat = icmp ? raw[15:0] : 16'(nst_pkg::DYN_LOW + raw % 32'd64512);
        if (nat != 0) begin
          s = victim_slot();
          was_v = sess_valid[s];
          sess_hosts[s] = hosts;
          sess_ports[s] = ports;
          sess_nat[s] = nat;
          sess_valid[s] = 1;
          make_recent(s, was_v);
          ridx = int'(slot_proto) * nst_pkg::PORT_SPACE + int'(nat);
          rmap_ip[ridx] = sip;
          rmap_port[ridx] = sp;
        end
      end
      if (nat != 0) begin
        r.act = nst_pkg::ACT_OUT;
        r.sip = cfg_public;
        r.sp = nat;
        if (icmp) r.dp = nat;
      end
    end else if (dip == cfg_public && parsed) begin
      key = icmp ? sp : dp;
      ridx = int'(slot_proto) * nst_pkg::PORT_SPACE + int'(key);
      if (rmap_ip.exists(ridx)) begin
        r.act = nst_pkg::ACT_IN;
        r.dip = rmap_ip[ridx];
        r.dp = rmap_port[ridx];
        if (icmp) r.sp = r.dp;
      end
    end
    return r;
  endfunction

  // Register writes, accepted headers and delivered results.
  always @(posedge clk) begin
    xlat_t want;
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          nst_pkg::REG_SUBNET: cfg_subnet <= pwdata;
          nst_pkg::REG_MASK:   cfg_mask   <= pwdata;
          nst_pkg::REG_PUBLIC: cfg_public <= pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_xlat.push_back(translate(is_ipv4, fragmented, protocol, src_ip, dst_ip,
                                          src_port, dst_port, icmp_type, l4_header_ok));
      if (out_valid && !out_stall) begin
        if (expected_xlat.size() == 0) begin
          $error("result transaction with no header waiting");
          fails++;
        end else begin
          want = expected_xlat.pop_front();
          if (action !== want.act) begin
            $error("action: expected %0d, got %0d", want.act, action);
            fails++;
          end
          if (new_src_ip !== want.sip) begin
            $error("new_src_ip: expected %h, got %h", want.sip, new_src_ip);
            fails++;
          end
          if (new_dst_ip !== want.dip) begin
            $error("new_dst_ip: expected %h, got %h", want.dip, new_dst_ip);
            fails++;
          end
          if (new_src_port !== want.sp) begin
            $error("new_src_port: expected %0d, got %0d", want.sp, new_src_port);
            fails++;
          end
          if (new_dst_port !== want.dp) begin
            $error("new_dst_port: expected %0d, got %0d", want.dp, new_dst_port);
            fails++;
          end
        end
      end
    end
  end

endmodule

/* tb/sv/nat_session_translation_top_test.sv */
// Top of the NAT session translation testbench: clock, reset, stimulus and verdict.
module nat_session_translation_top_test;

  localparam int LIMIT  = 12_000_000;
  localparam int SETTLE = 2200;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 0;
  logic        in_stall;
  logic        is_ipv4 = 0, fragmented = 0, l4_header_ok = 0;
  logic [7:0]  protocol = '0, icmp_type = '0;
  logic [31:0] src_ip = '0, dst_ip = '0;
  logic [15:0] src_port = '0, dst_port = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  action;
  logic [31:0] new_src_ip, new_dst_ip;
  logic [15:0] new_src_port, new_dst_port;
  int          fails, pending;
  int          cycles = 0;
  int          burst_left = 0;
  logic [31:0] net = '0, mask = '0, pub = '0;

  nat_session_translation_top u_top (.*);
  nat_session_translation_checker u_chk (.*);

  initial forever #4 clk = ~clk;

  // Safety limit on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver stall pattern: four modes in turn, no stall, light, heavy and even random stall.
  always @(posedge clk) begin
    int mode;
    mode = (cycles / 64) % 4;
    case (mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= 1'($urandom_range(0, 1));
    endcase
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] s, logic [31:0] m, logic [31:0] p);
    net = s;
    mask = m;
    pub = p;
    reg_write(nst_pkg::REG_SUBNET, s);
    reg_write(nst_pkg::REG_MASK, m);
    reg_write(nst_pkg::REG_PUBLIC, p);
  endtask

  // Wait until every result is in, then let the block go idle.
  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Drive one header transaction, with bursts and random gaps between them.
  task automatic send(logic v4, logic frag, logic [7:0] pr, logic [31:0] sip, logic [31:0] dip,
                      logic [15:0] sp, logic [15:0] dp, logic [7:0] ty, logic ok);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 20);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1;
    is_ipv4 <= v4;
    fragmented <= frag;
    protocol <= pr;
    src_ip <= sip;
    dst_ip <= dip;
    src_port <= sp;
    dst_port <= dp;
    icmp_type <= ty;
    l4_header_ok <= ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic stop_sending();
    in_valid <= 0;
    burst_left = 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] inside_host(int idx);
    return (net & mask) | (32'(idx * 37 + 1) & ~mask);
  endfunction

  // An address that is not inside unless the mask is zero: flip the lowest mask bit when needed.
  function automatic logic [31:0] outside_host(logic [31:0] a);
    if ((a & mask) == net) a ^= mask & (~mask + 1);
    return a;
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 2))
      0: return nst_pkg::PROTO_TCP;
      1: return nst_pkg::PROTO_UDP;
      default: return nst_pkg::PROTO_ICMP;
    endcase
  endfunction

  // Random traffic: mostly sessions and their replies, the rest noise.
  task automatic random_traffic(int count);
    int kind;
    logic [7:0] pr, ty;
    logic [15:0] sp, dp;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      pr = pick_proto();
      ty = $urandom_range(0, 1) ? nst_pkg::ICMP_REQ : nst_pkg::ICMP_REPLY;
      if (kind < 55) begin
        sp = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        dp = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(80, 83));
        send(1, 0, pr, inside_host($urandom_range(0, 7)),
             outside_host(32'hC633_6400 | $urandom_range(0, 7)), sp, dp, ty, 1);
      end else if (kind < 80) begin
        sp = 16'($urandom_range(0, 300));
        dp = 16'(1024 + $urandom_range(0, 300));
        if ($urandom_range(0, 9) == 0) begin
          sp = 16'($urandom);
          dp = 16'($urandom);
        end
        send(1, 0, pr, outside_host($urandom), pub, sp, dp, ty, 1);
      end else begin
        case ($urandom_range(0, 3))
          0: pr = nst_pkg::PROTO_TCP;
          1: pr = nst_pkg::PROTO_UDP;
          2: pr = nst_pkg::PROTO_ICMP;
          default: pr = 8'($urandom);
        endcase
        send(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pr,
             $urandom_range(0, 1) ? inside_host($urandom_range(0, 7)) : $urandom,
             $urandom_range(0, 1) ? pub : $urandom, 16'($urandom), 16'($urandom),
             $urandom_range(0, 1) ? ty : 8'($urandom), 1'($urandom_range(0, 1)));
      end
    end
    stop_sending();
  endtask

  // Main sequence: reset, phases of configuration, verdict.
  initial begin
    logic [31:0] ih, oh;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Registers at reset: everything counts as inside, nothing translates outbound.
    random_traffic(30);
    settle();

    // Directed headers.
    set_config(32'h0A00_0000, 32'hFF00_0000, 32'hC633_6401);
    ih = inside_host(0);
    oh = outside_host(32'hC633_6410);
    send(0, 0, nst_pkg::PROTO_TCP, ih, oh, 16'd1, 16'd80, nst_pkg::ICMP_REQ, 1);  // not IPv4
    send(1, 1, nst_pkg::PROTO_TCP, ih, oh, 16'd1, 16'd80, nst_pkg::ICMP_REQ, 1);  // fragment
    send(1, 0, 8'd0, ih, oh, 16'd1, 16'd80, nst_pkg::ICMP_REQ, 1);       // unknown protocol
    send(1, 0, 8'hFF, ih, oh, 16'hFFFF, 16'hFFFF, 8'hFF, 1);
    send(1, 0, nst_pkg::PROTO_TCP, ih, oh, 16'd1, 16'd80, nst_pkg::ICMP_REQ, 0);  // short L4
    send(1, 0, nst_pkg::PROTO_ICMP, ih, oh, 16'd5, 16'd0, 8'd3, 1);      // other ICMP type
    send(1, 0, nst_pkg::PROTO_TCP, ih, oh, 16'd1, 16'd80, nst_pkg::ICMP_REQ, 1);  // new TCP
    send(1, 0, nst_pkg::PROTO_TCP, ih, oh, 16'd1, 16'd80, nst_pkg::ICMP_REQ, 1);  // hit
    send(1, 0, nst_pkg::PROTO_UDP, ih, oh, 16'hFFFF, 16'hFFFF, nst_pkg::ICMP_REQ, 1); // new UDP
    send(1, 0, nst_pkg::PROTO_ICMP, ih, oh, 16'd7, 16'd9, nst_pkg::ICMP_REQ, 1);  // id 0 passes
    send(1, 0, nst_pkg::PROTO_ICMP, ih, oh, 16'd7, 16'd9, nst_pkg::ICMP_REQ, 1);  // gets id 1
    send(1, 0, nst_pkg::PROTO_TCP, oh, 32'hC633_6401, 16'd80, 16'd1024, 8'd0, 1); // inbound TCP
    send(1, 0, nst_pkg::PROTO_UDP, oh, 32'hC633_6401, 16'd9, 16'd1024, 8'd0, 1);  // inbound UDP
    send(1, 0, nst_pkg::PROTO_ICMP, oh, 32'hC633_6401, 16'd1, 16'd0, nst_pkg::ICMP_REPLY, 1);
    send(1, 0, nst_pkg::PROTO_TCP, oh, 32'hC633_6401, 16'd80, 16'hFFFF, 8'd0, 1); // miss
    send(1, 0, 8'd50, ih, oh, 16'd1, 16'd2, 8'd0, 1);                  // outbound, unparsed
    send(1, 0, nst_pkg::PROTO_TCP, ih, inside_host(3), 16'd1, 16'd2, 8'd0, 1);  // inside only
    send(1, 0, nst_pkg::PROTO_TCP, ih, 32'hC633_6401, 16'd1, 16'd1024, 8'd0, 1); // to public
    send(1, 1, nst_pkg::PROTO_TCP, oh, 32'hC633_6401, 16'd80, 16'd1024, 8'd0, 1); // fragment
    send(1, 0, nst_pkg::PROTO_TCP, 32'hFFFF_FFFF, 32'h0000_0000, 16'd0, 16'd0, 8'd0, 1);
    stop_sending();
    random_traffic(300);
    settle();

    // All-ones registers: a single inside host.
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_traffic(250);
    settle();

    // A /16 inside network and a zero public address.
    set_config(32'hC0A8_0000, 32'hFFFF_0000, 32'h0000_0000);
    random_traffic(370);
    settle();

    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* nat_session_translation_top.f */
+incdir+design
design/nst_pkg.sv
design/nst_ram.sv
design/nst_cfg_regs.sv
design/nat_session_translation_top.sv
tb/sv/nat_session_translation_checker.sv
tb/sv/nat_session_translation_top_test.sv
